/* src/jbt_pkg.sv */
// ----------------------------------------------------------------------------
// jbt_pkg
// Shared types and constants for the JSON byte tokenizer: lexer modes,
// token kinds, character codes and the result record.
// ----------------------------------------------------------------------------
package jbt_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_STR  = 3'd1,
    MODE_INT  = 3'd2,
    MODE_FRAC = 3'd3,
    MODE_ERR  = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    KIND_LBRACE   = 4'd0,
    KIND_RBRACE   = 4'd1,
    KIND_LBRACKET = 4'd2,
    KIND_RBRACKET = 4'd3,
    KIND_COMMA    = 4'd4,
    KIND_COLON    = 4'd5,
    KIND_STRING   = 4'd6,
    KIND_INTEGER  = 4'd7,
    KIND_FLOAT    = 4'd8,
    KIND_ERROR    = 4'd9,
    KIND_DOCEND   = 4'd10
  } kind_t;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_POINT    = 8'h2E;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;

  // result queue depth; one byte may add two results
  localparam int unsigned QUEUE_DEPTH = 3;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] content_byte;
    logic       has_content;
    logic       token_end;
    logic       run_last;
  } result_t;

  typedef struct packed {
    result_t     res0;
    result_t     res1;
    logic [1:0]  count;
    mode_t       mode_next;
  } decode_t;

endpackage

/* src/jbt_decode.sv */
// ----------------------------------------------------------------------------
// jbt_decode
// Combinational lexer step: from the current mode and one document byte,
// forms up to two results and the next mode.
// ----------------------------------------------------------------------------
module jbt_decode (
  input  jbt_pkg::mode_t   mode,
  input  logic [7:0]       byte_in,
  output jbt_pkg::decode_t dec
);
  import jbt_pkg::*;

  typedef struct packed {
    logic    valid;
    result_t res;
    mode_t   mode;
  } idle_t;

  function automatic result_t make_res(kind_t k, logic [7:0] b, logic has, logic fin);
    result_t r;
    r.kind         = k;
    r.content_byte = has ? b : 8'h00;
    r.has_content  = has;
    r.token_end    = fin;
    r.run_last     = 1'b0;
    return r;
  endfunction

  function automatic idle_t idle_byte(logic [7:0] b);
    idle_t o;
    o.valid = 1'b1;
    o.mode  = MODE_IDLE;
    o.res   = make_res(KIND_DOCEND, 8'h00, 1'b0, 1'b1);
    case (b)
      CH_LBRACE:   o.res = make_res(KIND_LBRACE, b, 1'b1, 1'b1);
      CH_RBRACE:   o.res = make_res(KIND_RBRACE, b, 1'b1, 1'b1);
      CH_LBRACKET: o.res = make_res(KIND_LBRACKET, b, 1'b1, 1'b1);
      CH_RBRACKET: o.res = make_res(KIND_RBRACKET, b, 1'b1, 1'b1);
      CH_COMMA:    o.res = make_res(KIND_COMMA, b, 1'b1, 1'b1);
      CH_COLON:    o.res = make_res(KIND_COLON, b, 1'b1, 1'b1);
      CH_SPACE, CH_LF, CH_CR: o.valid = 1'b0;
      CH_QUOTE: begin
        o.valid = 1'b0;
        o.mode  = MODE_STR;
      end
      CH_NUL:      o.res = make_res(KIND_DOCEND, 8'h00, 1'b0, 1'b1);
      default: begin
        if (b inside {[CH_ZERO:CH_NINE]}) begin
          o.res  = make_res(KIND_INTEGER, b, 1'b1, 1'b0);
          o.mode = MODE_INT;
        end else begin
          o.res  = make_res(KIND_ERROR, b, 1'b1, 1'b1);
          o.mode = MODE_ERR;
        end
      end
    endcase
    return o;
  endfunction

  idle_t   idle;
  logic    is_digit;
  result_t r0;
  result_t r1;
  logic [1:0] n;
  mode_t   mnext;

  assign idle     = idle_byte(byte_in);
  assign is_digit = byte_in inside {[CH_ZERO:CH_NINE]};

  always_comb begin
    r0    = idle.res;
    r1    = idle.res;
    n     = 2'd0;
    mnext = mode;
    case (mode)
      MODE_IDLE: begin
        n     = {1'b0, idle.valid};
        mnext = idle.mode;
      end
      MODE_STR: begin
        n = 2'd1;
        if (byte_in == CH_QUOTE) begin
          r0    = make_res(KIND_STRING, 8'h00, 1'b0, 1'b1);
          mnext = MODE_IDLE;
        end else if (byte_in == CH_NUL) begin
          r0    = make_res(KIND_ERROR, 8'h00, 1'b1, 1'b1);
          mnext = MODE_ERR;
        end else begin
          r0 = make_res(KIND_STRING, byte_in, 1'b1, 1'b0);
        end
      end
      MODE_INT: begin
        if (is_digit) begin
          n  = 2'd1;
          r0 = make_res(KIND_INTEGER, byte_in, 1'b1, 1'b0);
        end else if (byte_in == CH_POINT) begin
          n     = 2'd1;
          r0    = make_res(KIND_FLOAT, byte_in, 1'b1, 1'b0);
          mnext = MODE_FRAC;
        end else begin
          r0    = make_res(KIND_INTEGER, 8'h00, 1'b0, 1'b1);
          n     = idle.valid ? 2'd2 : 2'd1;
          mnext = idle.mode;
        end
      end
      MODE_FRAC: begin
        if (is_digit) begin
          n  = 2'd1;
          r0 = make_res(KIND_FLOAT, byte_in, 1'b1, 1'b0);
        end else begin
          r0    = make_res(KIND_FLOAT, 8'h00, 1'b0, 1'b1);
          n     = idle.valid ? 2'd2 : 2'd1;
          mnext = idle.mode;
        end
      end
      default: begin
        n     = 2'd0;
        mnext = MODE_ERR;
      end
    endcase
    r0.run_last = (n == 2'd1);
    r1.run_last = 1'b1;
  end

  assign dec.res0      = r0;
  assign dec.res1      = r1;
  assign dec.count     = n;
  assign dec.mode_next = mnext;

endmodule

/* src/jbt_out_queue.sv */
// ----------------------------------------------------------------------------
// jbt_out_queue
// Shifting result queue: takes zero, one or two results a cycle, presents
// the oldest on the output stream and reports its free room.
// ----------------------------------------------------------------------------
module jbt_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_n,
  input  jbt_pkg::result_t  push0,
  input  jbt_pkg::result_t  push1,
  output logic [1:0]        free,
  output jbt_pkg::result_t  head,
  output logic              head_valid,
  input  logic              pop_ready
);
  import jbt_pkg::*;

  result_t    q      [QUEUE_DEPTH];
  result_t    q_next [QUEUE_DEPTH];
  logic [1:0] count;
  logic [1:0] count_next;
  logic [1:0] base;
  logic       pop;

  assign head_valid = (count != 2'd0);
  assign head       = q[0];
  assign pop        = head_valid && pop_ready;
  assign base       = count - {1'b0, pop};
  assign free       = 2'(QUEUE_DEPTH) - count;
  assign count_next = base + push_n;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (pop && (i < QUEUE_DEPTH - 1)) begin
        q_next[i] = q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
      end else begin
        q_next[i] = q[i];
      end
      if ((3'(i) == {1'b0, base}) && (push_n != 2'd0)) begin
        q_next[i] = push0;
      end else if ((3'(i) == ({1'b0, base} + 3'd1)) && (push_n == 2'd2)) begin
        q_next[i] = push1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

endmodule

/* src/json_byte_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// json_byte_tokenizer_core
// Streaming tokenizer for a small JSON subset, one document byte a request.
// ----------------------------------------------------------------------------
// Slave stream s_*: one document byte per request in s_tdata; byte 0 ends
// the document. Master stream m_*: one token result per request; tdata is
// the content byte, tuser carries kind, has_content and token_end, and
// tlast marks the last result caused by one input byte.
// Path: a taken byte is held in the input register, decoded there and
// pushed into the result queue once it has room; the queue head drives m_*.
// Throughput: one byte per cycle while each byte gives at most one result
// and m_tready stays high; a byte that closes a number and opens a token
// gives two results, pushed together and sent one after the other. The
// lexer mode register and a three-entry result queue set this rate.
// Reset: mode returns to idle, input and result queues are emptied.
// Stall: while m_tready is low results wait in the queue; once it cannot
// hold the next byte's results, s_tready drops. s_tready never depends
// combinationally on m_tready.
// ----------------------------------------------------------------------------
module json_byte_tokenizer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] byte_in
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] content_byte
  output logic [5:0] m_tuser,   // [3:0] kind, [4] has_content, [5] token_end
  output logic       m_tlast    // run_last
);
  import jbt_pkg::*;

  logic       in_valid;
  logic       in_valid_next;
  logic [7:0] in_byte;
  mode_t      mode;
  decode_t    dec;
  logic [1:0] free;
  logic       fire;
  logic       s_accept;
  result_t    head;

  jbt_decode u_decode (
    .mode    (mode),
    .byte_in (in_byte),
    .dec     (dec)
  );

  assign fire          = in_valid && (dec.count <= free);
  assign s_tready      = !in_valid || fire;
  assign s_accept      = s_tvalid && s_tready;
  assign in_valid_next = s_accept ? 1'b1 : (fire ? 1'b0 : in_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      mode     <= MODE_IDLE;
    end else begin
      in_valid <= in_valid_next;
      if (fire) begin
        mode <= dec.mode_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_byte <= s_tdata;
    end
  end

  jbt_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_n     (fire ? dec.count : 2'd0),
    .push0      (dec.res0),
    .push1      (dec.res1),
    .free       (free),
    .head       (head),
    .head_valid (m_tvalid),
    .pop_ready  (m_tready)
  );

  assign m_tdata = head.content_byte;
  assign m_tuser = {head.token_end, head.has_content, head.kind};
  assign m_tlast = head.run_last;

endmodule

/* src/jbt_checker.sv */
// ----------------------------------------------------------------------------
// jbt_checker
// Port-level checks on the tokenizer's result stream, bound to the top.
// ----------------------------------------------------------------------------
module jbt_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [5:0] m_tuser,
  input logic       m_tlast
);
  import jbt_pkg::*;

  logic single_tok;

  assign single_tok = (m_tuser[3:0] == KIND_LBRACE) || (m_tuser[3:0] == KIND_RBRACE) ||
                      (m_tuser[3:0] == KIND_LBRACKET) || (m_tuser[3:0] == KIND_RBRACKET) ||
                      (m_tuser[3:0] == KIND_COMMA) || (m_tuser[3:0] == KIND_COLON) ||
                      (m_tuser[3:0] == KIND_ERROR) || (m_tuser[3:0] == KIND_DOCEND);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_no_content: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[4] |-> (m_tdata == 8'h00))
    else $error("content byte set without has_content");

  a_single_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && single_tok |-> m_tuser[5] && m_tlast)
    else $error("single-result token not closed as last result");

endmodule

bind json_byte_tokenizer_core jbt_checker u_jbt_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for json_byte_tokenizer_core. Document bytes go in
// on the slave stream and a lexer model in the bench predicts every token
// result. A checker compares each result on the master stream with the
// oldest prediction. The directed tests cover punctuation, blanks, strings,
// integers, floats and document end. Random documents follow. The run ends
// with the sticky error, which only reset clears.
// ----------------------------------------------------------------------------
module tb;
  import jbt_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [5:0] m_tuser;
  logic       m_tlast;

  localparam logic [47:0] PUNCT  = {CH_COLON, CH_COMMA, CH_RBRACKET, CH_LBRACKET,
                                    CH_RBRACE, CH_LBRACE};
  localparam logic [23:0] BLANKS = {CH_CR, CH_LF, CH_SPACE};

  json_byte_tokenizer_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // lexer model state and expected token results
  mode_t   lex_mode = MODE_IDLE;
  result_t expected_tokens[$];
  result_t step_res[2];
  int      step_n;
  int      fail_count = 0;
  int      bytes_sent = 0;
  logic    gaps_on = 1'b1;

  function automatic logic is_digit(logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic void add_token(kind_t k, logic [7:0] c, logic has, logic fin);
    step_res[step_n].kind         = k;
    step_res[step_n].content_byte = has ? c : 8'h00;
    step_res[step_n].has_content  = has;
    step_res[step_n].token_end    = fin;
    step_res[step_n].run_last     = 1'b0;
    step_n++;
  endfunction

  function automatic void lex_idle(logic [7:0] b);
    lex_mode = MODE_IDLE;
    case (b)
      CH_LBRACE:   add_token(KIND_LBRACE, b, 1'b1, 1'b1);
      CH_RBRACE:   add_token(KIND_RBRACE, b, 1'b1, 1'b1);
      CH_LBRACKET: add_token(KIND_LBRACKET, b, 1'b1, 1'b1);
      CH_RBRACKET: add_token(KIND_RBRACKET, b, 1'b1, 1'b1);
      CH_COMMA:    add_token(KIND_COMMA, b, 1'b1, 1'b1);
      CH_COLON:    add_token(KIND_COLON, b, 1'b1, 1'b1);
      CH_SPACE, CH_LF, CH_CR: begin
      end
      CH_QUOTE:    lex_mode = MODE_STR;
      CH_NUL:      add_token(KIND_DOCEND, b, 1'b0, 1'b1);
      default: begin
        if (is_digit(b)) begin
          add_token(KIND_INTEGER, b, 1'b1, 1'b0);
          lex_mode = MODE_INT;
        end else begin
          add_token(KIND_ERROR, b, 1'b1, 1'b1);
          lex_mode = MODE_ERR;
        end
      end
    endcase
  endfunction

  function automatic void lex_byte(logic [7:0] b);
    result_t r;
    step_n = 0;
    case (lex_mode)
      MODE_IDLE: lex_idle(b);
      MODE_STR: begin
        if (b == CH_QUOTE) begin
          add_token(KIND_STRING, 8'h00, 1'b0, 1'b1);
          lex_mode = MODE_IDLE;
        end else if (b == CH_NUL) begin
          add_token(KIND_ERROR, 8'h00, 1'b1, 1'b1);
          lex_mode = MODE_ERR;
        end else begin
          add_token(KIND_STRING, b, 1'b1, 1'b0);
        end
      end
      MODE_INT: begin
        if (is_digit(b)) begin
          add_token(KIND_INTEGER, b, 1'b1, 1'b0);
        end else if (b == CH_POINT) begin
          add_token(KIND_FLOAT, b, 1'b1, 1'b0);
          lex_mode = MODE_FRAC;
        end else begin
          add_token(KIND_INTEGER, 8'h00, 1'b0, 1'b1);
          lex_idle(b);
        end
      end
      MODE_FRAC: begin
        if (is_digit(b)) begin
          add_token(KIND_FLOAT, b, 1'b1, 1'b0);
        end else begin
          add_token(KIND_FLOAT, 8'h00, 1'b0, 1'b1);
          lex_idle(b);
        end
      end
      default: lex_mode = MODE_ERR;
    endcase
    for (int i = 0; i < step_n; i++) begin
      r = step_res[i];
      r.run_last = (i == step_n - 1);
      expected_tokens.push_back(r);
    end
  endfunction

  // one request on the slave side; valid stays high across back-to-back bytes
  task automatic send_byte(logic [7:0] b);
    if (gaps_on) begin
      while ($urandom_range(99) < 22) begin
        s_tvalid <= 1'b0;
        s_tdata  <= 8'($urandom_range(255));
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    lex_byte(b);
    bytes_sent++;
  endtask

  task automatic send_digit;
    send_byte(CH_ZERO + 8'($urandom_range(9)));
  endtask

  always @(posedge clk) begin
    m_tready <= rst ? 1'b0 : !(gaps_on && $urandom_range(99) < 22);
  end

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.kind         = kind_t'(m_tuser[3:0]);
      got.content_byte = m_tdata;
      got.has_content  = m_tuser[4];
      got.token_end    = m_tuser[5];
      got.run_last     = m_tlast;
      if (expected_tokens.size() == 0) begin
        $error("unexpected result: kind %0d, content %h", got.kind, got.content_byte);
        fail_count++;
      end else begin
        want = expected_tokens.pop_front();
        if (got.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, got.kind);
          fail_count++;
        end
        if (got.content_byte !== want.content_byte) begin
          $error("content_byte: expected %h, got %h", want.content_byte, got.content_byte);
          fail_count++;
        end
        if (got.has_content !== want.has_content) begin
          $error("has_content: expected %b, got %b", want.has_content, got.has_content);
          fail_count++;
        end
        if (got.token_end !== want.token_end) begin
          $error("token_end: expected %b, got %b", want.token_end, got.token_end);
          fail_count++;
        end
        if (got.run_last !== want.run_last) begin
          $error("run_last: expected %b, got %b", want.run_last, got.run_last);
          fail_count++;
        end
      end
    end
  end

  task automatic test_punctuation;
    for (int i = 0; i < 6; i++) send_byte(PUNCT[8*i +: 8]);
    for (int i = 0; i < 3; i++) send_byte(BLANKS[8*i +: 8]);
    send_byte(CH_NUL);
  endtask

  // empty string, then one holding byte extremes and a brace
  task automatic test_strings;
    send_byte(CH_QUOTE);
    send_byte(CH_QUOTE);
    send_byte(CH_QUOTE);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(CH_RBRACE);
    send_byte(CH_QUOTE);
  endtask

  // float closed by punctuation, integer closed by document end
  task automatic test_numbers;
    send_byte(CH_ZERO);
    send_byte(CH_NINE);
    send_byte(CH_POINT);
    send_byte(CH_ZERO + 8'd5);
    send_byte(CH_RBRACKET);
    send_byte(CH_ZERO + 8'd1);
    send_byte(CH_NUL);
  endtask

  task automatic test_random_documents;
    int   start;
    int   doc;
    int   pick;
    logic after_number;
    logic [7:0] sb;
    start = bytes_sent;
    doc   = 0;
    while (bytes_sent - start < 2000) begin
      gaps_on <= !(doc >= 30 && doc < 50);
      after_number = 1'b0;
      repeat ($urandom_range(1, 12)) begin
        pick = $urandom_range(99);
        if (pick < 25) begin
          send_byte(PUNCT[8*$urandom_range(5) +: 8]);
          after_number = 1'b0;
        end else if (pick < 35) begin
          send_byte(BLANKS[8*$urandom_range(2) +: 8]);
          after_number = 1'b0;
        end else if (pick < 65) begin
          send_byte(CH_QUOTE);
          repeat ($urandom_range(0, 8)) begin
            do sb = 8'($urandom_range(1, 255)); while (sb == CH_QUOTE);
            send_byte(sb);
          end
          send_byte(CH_QUOTE);
          after_number = 1'b0;
        end else begin
          // a second point would error, so keep numbers apart
          if (after_number) send_byte(CH_SPACE);
          repeat ($urandom_range(1, 4)) send_digit();
          if (pick >= 85) begin
            send_byte(CH_POINT);
            repeat ($urandom_range(0, 3)) send_digit();
          end
          after_number = 1'b1;
        end
      end
      send_byte(CH_NUL);
      doc++;
    end
    gaps_on <= 1'b1;
  endtask

  // error is sticky until reset, so this runs last
  task automatic test_sticky_error;
    logic [7:0] bad;
    bad = $urandom_range(1) ? 8'($urandom_range(8'h80, 8'hFF))
                            : 8'($urandom_range(8'h61, 8'h7A));
    case ($urandom_range(2))
      0: send_byte(bad);
      1: begin
        send_byte(CH_QUOTE);
        send_byte(CH_ZERO + 8'd3);
        send_byte(CH_NUL);
      end
      default: begin
        send_digit();
        send_byte(bad);
      end
    endcase
    send_byte(CH_NUL);
    repeat (20) send_byte(8'($urandom_range(255)));
    send_byte(CH_NUL);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_punctuation();
    test_strings();
    test_numbers();
    test_random_documents();
    test_sticky_error();
    s_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
